FILE: design/fpec_pkg.sv
// Package for the flash program/erase controller.
// Holds the channel word types, field codes, register layouts and sweep types.
// No dependencies.
package fpec_pkg;

  localparam int PAGE_HALFWORDS = 1024;
  localparam int NUM_PAGES      = 4;
  localparam int TOTAL_CELLS    = PAGE_HALFWORDS * NUM_PAGES;
  localparam int MEM_AW         = $clog2(TOTAL_CELLS);
  localparam int CELL_W         = 16;
  localparam int ERASE_ADDR_W   = 13;
  localparam int HALF_ADDR_W    = ERASE_ADDR_W - 1;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [2:0] TGT_ARRAY   = 3'd0;
  localparam logic [2:0] TGT_KEY     = 3'd1;
  localparam logic [2:0] TGT_STATUS  = 3'd2;
  localparam logic [2:0] TGT_CONTROL = 3'd3;
  localparam logic [2:0] TGT_ADDRESS = 3'd4;

  localparam logic [2:0] ACC_OK     = 3'd0;
  localparam logic [2:0] ACC_LOCKED = 3'd1;
  localparam logic [2:0] ACC_BUSY   = 3'd2;
  localparam logic [2:0] ACC_PGERR  = 3'd3;
  localparam logic [2:0] ACC_NOPG   = 3'd4;

  localparam logic [1:0] CFG_KEY_FIRST   = 2'd0;
  localparam logic [1:0] CFG_KEY_SECOND  = 2'd1;
  localparam logic [1:0] CFG_PROG_TICKS  = 2'd2;
  localparam logic [1:0] CFG_ERASE_TICKS = 2'd3;

  localparam logic [31:0] KEY_FIRST_RST   = 32'h4567_0123;
  localparam logic [31:0] KEY_SECOND_RST  = 32'hCDEF_89AB;
  localparam logic [15:0] PROG_TICKS_RST  = 16'd4;
  localparam logic [15:0] ERASE_TICKS_RST = 16'd1000;

  localparam int SR_BSY    = 0;
  localparam int SR_PGERR  = 2;
  localparam int SR_EOP    = 5;
  localparam int CR_PG     = 0;
  localparam int CR_PER    = 1;
  localparam int CR_STRT   = 6;
  localparam int CR_LOCK   = 7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  target;
    logic [11:0] array_index;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  access_status;
    logic        busy_res;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [MEM_AW-1:0] first;
    logic [MEM_AW-1:0] last;
  } sweep_req_t;

  typedef struct packed {
    logic              active;
    logic [MEM_AW-1:0] addr;
  } sweep_st_t;

endpackage

FILE: design/fpec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fpec_sweep.sv
// Fill-address sequencer: walks a cell range one address per cycle.
// Runs over the whole array after reset. Depends on fpec_pkg.
module fpec_sweep
  import fpec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sweep_req_t req_i,
  output sweep_st_t  st_o
);

  logic              active_q, active_d;
  logic [MEM_AW-1:0] addr_q, addr_d;
  logic [MEM_AW-1:0] last_q, last_d;

  always_comb begin
    active_d = active_q;
    addr_d   = addr_q;
    last_d   = last_q;
    if (req_i.start) begin
      active_d = 1'b1;
      addr_d   = req_i.first;
      last_d   = req_i.last;
    end else if (active_q) begin
      if (addr_q == last_q) begin
        active_d = 1'b0;
      end else begin
        addr_d = addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      addr_q   <= '0;
      last_q   <= MEM_AW'(TOTAL_CELLS - 1);
    end else begin
      active_q <= active_d;
      addr_q   <= addr_d;
      last_q   <= last_d;
    end
  end

  assign st_o.active = active_q;
  assign st_o.addr   = addr_q;

endmodule

FILE: design/flash_program_erase_controller.sv
// Top level of the flash program/erase controller.
// Depends on fpec_pkg, fpec_ram and fpec_sweep.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one word per
//   bus read, bus write or busy tick. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns exactly one result word per input word.
//   Config channel (cfg_valid_i / cfg_ready_o) is always ready; write it only
//   while no word is in flight.
//   The input word is registered when taken, and its result is registered when
//   it executes in EXEC. A new word is taken only once the last has executed,
//   set by the read-modify-write of the cell array (read in the accept cycle,
//   modified and written back in EXEC). Page erase: after the result of the
//   starting control write, the input stalls while the PAGE_HALFWORDS cells
//   (1024) of the page are written with ones, one cell per cycle.
//   Reset: config and control registers take their reset values and the whole
//   cell array, TOTAL_CELLS cells (4096), is filled with ones, input stalled.
//   Output stall: a result waits in the output register; one more input word
//   is taken and then held until the output register frees.
module flash_program_erase_controller
  import fpec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_e;

  state_e                  state_q, state_d;
  in_t                     item_q, item_d;
  out_t                    out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic [31:0]             key1_q, key1_d;
  logic [31:0]             key2_q, key2_d;
  logic [15:0]             prog_ticks_q, prog_ticks_d;
  logic [15:0]             erase_ticks_q, erase_ticks_d;
  logic                    locked_q, locked_d;
  logic                    key_stage_q, key_stage_d;
  logic                    prog_en_q, prog_en_d;
  logic                    per_en_q, per_en_d;
  logic [ERASE_ADDR_W-1:0] erase_addr_q, erase_addr_d;
  logic [15:0]             busy_ticks_q, busy_ticks_d;
  logic                    pgerr_q, pgerr_d;
  logic                    eop_q, eop_d;

  logic                    in_accept;
  logic                    exec_fire;
  logic                    busy;
  logic                    in_range;
  logic [CELL_W-1:0]       rdata;
  logic [CELL_W-1:0]       wdata16;
  logic                    exec_we;
  logic [CELL_W-1:0]       exec_wdata;
  logic                    ram_we;
  logic [MEM_AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]       ram_wdata;
  logic [HALF_ADDR_W-1:0]  half_addr;
  logic [HALF_ADDR_W-1:0]  page_num;
  logic [31:0]             page_base;
  logic                    page_ok;
  logic [31:0]             status_word;
  logic [31:0]             control_word;
  sweep_req_t              sweep_req;
  sweep_st_t               sweep_st;

  assign in_stall_o  = (state_q != IDLE) || sweep_st.active;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign exec_fire   = (state_q == EXEC) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign busy      = busy_ticks_q != 16'd0;
  assign in_range  = 32'(item_q.array_index) < TOTAL_CELLS;
  assign wdata16   = item_q.write_data[CELL_W-1:0];
  assign half_addr = erase_addr_q[ERASE_ADDR_W-1:1];
  assign page_num  = HALF_ADDR_W'(32'(half_addr) / PAGE_HALFWORDS);
  assign page_base = 32'(page_num) * PAGE_HALFWORDS;
  assign page_ok   = 32'(half_addr) < TOTAL_CELLS;

  assign status_word  = {26'd0, eop_q, 2'd0, pgerr_q, 1'b0, busy};
  assign control_word = {24'd0, locked_q, 5'd0, per_en_q, prog_en_q};

  assign ram_we    = sweep_st.active || exec_we;
  assign ram_waddr = sweep_st.active ? sweep_st.addr : MEM_AW'(item_q.array_index);
  assign ram_wdata = sweep_st.active ? {CELL_W{1'b1}} : exec_wdata;

  fpec_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TOTAL_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (MEM_AW'(in_data_i.array_index)),
    .rdata_o (rdata)
  );

  fpec_sweep u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sweep_req),
    .st_o   (sweep_st)
  );

  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    key1_d        = key1_q;
    key2_d        = key2_q;
    prog_ticks_d  = prog_ticks_q;
    erase_ticks_d = erase_ticks_q;
    locked_d      = locked_q;
    key_stage_d   = key_stage_q;
    prog_en_d     = prog_en_q;
    per_en_d      = per_en_q;
    erase_addr_d  = erase_addr_q;
    busy_ticks_d  = busy_ticks_q;
    pgerr_d       = pgerr_q;
    eop_d         = eop_q;
    exec_we       = 1'b0;
    exec_wdata    = rdata & wdata16;
    sweep_req.start = 1'b0;
    sweep_req.first = MEM_AW'(page_base);
    sweep_req.last  = MEM_AW'(page_base + 32'(PAGE_HALFWORDS - 1));

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KEY_FIRST:   key1_d        = cfg_data_i;
        CFG_KEY_SECOND:  key2_d        = cfg_data_i;
        CFG_PROG_TICKS:  prog_ticks_d  = cfg_data_i[15:0];
        CFG_ERASE_TICKS: erase_ticks_d = cfg_data_i[15:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_accept) begin
      item_d  = in_data_i;
      state_d = EXEC;
    end

    if (exec_fire) begin
      out_d.read_data     = '0;
      out_d.access_status = ACC_OK;
      case (item_q.mode)
        MODE_READ: begin
          case (item_q.target)
            TGT_ARRAY:   out_d.read_data = in_range ? {16'd0, rdata} : 32'd0;
            TGT_STATUS:  out_d.read_data = status_word;
            TGT_CONTROL: out_d.read_data = control_word;
            TGT_ADDRESS: out_d.read_data = {19'd0, erase_addr_q};
            default: ;
          endcase
        end
        MODE_WRITE: begin
          case (item_q.target)
            TGT_ARRAY: begin
              if (busy) begin
                out_d.access_status = ACC_BUSY;
              end else if (locked_q) begin
                out_d.access_status = ACC_LOCKED;
              end else if (!prog_en_q) begin
                out_d.access_status = ACC_NOPG;
              end else if (in_range) begin
                exec_we      = 1'b1;
                busy_ticks_d = prog_ticks_q;
                eop_d        = 1'b1;
                if ((wdata16 & ~rdata) != '0) begin
                  pgerr_d             = 1'b1;
                  out_d.access_status = ACC_PGERR;
                end
              end
            end
            TGT_KEY: begin
              if (locked_q) begin
                if (!key_stage_q && item_q.write_data == key1_q) begin
                  key_stage_d = 1'b1;
                end else if (key_stage_q && item_q.write_data == key2_q) begin
                  key_stage_d = 1'b0;
                  locked_d    = 1'b0;
                end else begin
                  key_stage_d         = 1'b0;
                  out_d.access_status = ACC_LOCKED;
                end
              end
            end
            TGT_STATUS: begin
              if (item_q.write_data[SR_PGERR]) begin
                pgerr_d = 1'b0;
              end
              if (item_q.write_data[SR_EOP]) begin
                eop_d = 1'b0;
              end
            end
            TGT_CONTROL: begin
              if (locked_q) begin
                out_d.access_status = ACC_LOCKED;
              end else if (busy) begin
                out_d.access_status = ACC_BUSY;
              end else begin
                prog_en_d = item_q.write_data[CR_PG];
                per_en_d  = item_q.write_data[CR_PER];
                if (item_q.write_data[CR_STRT] && item_q.write_data[CR_PER]) begin
                  sweep_req.start = page_ok;
                  busy_ticks_d    = erase_ticks_q;
                  eop_d           = 1'b1;
                end
                if (item_q.write_data[CR_LOCK]) begin
                  locked_d    = 1'b1;
                  key_stage_d = 1'b0;
                end
              end
            end
            TGT_ADDRESS: begin
              if (busy) begin
                out_d.access_status = ACC_BUSY;
              end else begin
                erase_addr_d = item_q.write_data[ERASE_ADDR_W-1:0];
              end
            end
            default: ;
          endcase
        end
        MODE_TICK: begin
          if (busy) begin
            busy_ticks_d = busy_ticks_q - 16'd1;
          end
        end
        default: ;
      endcase
      out_d.busy_res = busy_ticks_d != 16'd0;
      out_valid_d    = 1'b1;
      state_d        = IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= IDLE;
      item_q        <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      key1_q        <= KEY_FIRST_RST;
      key2_q        <= KEY_SECOND_RST;
      prog_ticks_q  <= PROG_TICKS_RST;
      erase_ticks_q <= ERASE_TICKS_RST;
      locked_q      <= 1'b1;
      key_stage_q   <= 1'b0;
      prog_en_q     <= 1'b0;
      per_en_q      <= 1'b0;
      erase_addr_q  <= '0;
      busy_ticks_q  <= '0;
      pgerr_q       <= 1'b0;
      eop_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      item_q        <= item_d;
      out_q         <= out_d;
      out_valid_q   <= out_valid_d;
      key1_q        <= key1_d;
      key2_q        <= key2_d;
      prog_ticks_q  <= prog_ticks_d;
      erase_ticks_q <= erase_ticks_d;
      locked_q      <= locked_d;
      key_stage_q   <= key_stage_d;
      prog_en_q     <= prog_en_d;
      per_en_q      <= per_en_d;
      erase_addr_q  <= erase_addr_d;
      busy_ticks_q  <= busy_ticks_d;
      pgerr_q       <= pgerr_d;
      eop_q         <= eop_d;
    end
  end

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep_st.active && exec_we))
    else $error("cell write collides with fill sweep");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_req.start |=> (sweep_st.active && in_stall_o))
    else $error("erase sweep did not hold off the input");

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && item_q.mode == MODE_TICK && busy) |=>
      (busy_ticks_q == $past(busy_ticks_q) - 16'd1))
    else $error("tick did not lower busy count by one");

  a_result_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (out_valid_o && state_q == IDLE))
    else $error("executed word left no result");

endmodule
